FILE: design/voxel_brick_store_defines.svh
// ----------------------------------------------------------------------------
// voxel brick store assertion macros
// shared checks on the block's clock and asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef VOXEL_BRICK_STORE_DEFINES_SVH
`define VOXEL_BRICK_STORE_DEFINES_SVH

// same-cycle implication
`define VBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voxel_brick_store: same-cycle check failed");

// next-cycle implication
`define VBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voxel_brick_store: next-cycle check failed");

`endif

FILE: design/vbs_pkg.sv
// ----------------------------------------------------------------------------
// vbs_pkg
// types and constants of the voxel brick store
// ----------------------------------------------------------------------------
package vbs_pkg;

    localparam int EDGE        = 8;
    localparam int COORD_W     = $clog2(EDGE);
    localparam int POS_W       = 8;
    localparam int LAYER_BITS  = EDGE * EDGE;
    localparam int LAYER_IDX_W = $clog2(LAYER_BITS);
    localparam int VOXELS      = EDGE * EDGE * EDGE;
    localparam int IDX_W       = $clog2(VOXELS);
    localparam int CH_W        = 8;
    localparam int COLOUR_W    = 4 * CH_W;
    localparam int SUM_W       = 17;
    localparam int CNT_W       = 10;
    localparam int STEP_W      = $clog2(SUM_W);

    typedef enum logic [1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_SET     = 2'd1,
        KIND_READ    = 2'd2,
        KIND_SUMMARY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CHAN_RED   = 2'd0,
        CHAN_GREEN = 2'd1,
        CHAN_BLUE  = 2'd2
    } chan_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FETCH  = 5'b00010,
        ST_APPLY  = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage

FILE: design/vbs_ram.sv
// ----------------------------------------------------------------------------
// vbs_ram
// generic single-write single-read memory with registered read data
// ----------------------------------------------------------------------------
module vbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/voxel_brick_store.sv
// ----------------------------------------------------------------------------
// voxel_brick_store
// one voxel brick: per-layer occupancy masks, colour memory, running colour
// sums, voxel access and average-colour summary
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  --------+------------------------------+-----------------------------------
//  in      | in_valid / in_stall          | kind, pos_x/y/z, colour, replace
//  out     | out_valid / out_stall        | bad_position, solid, colour,
//          |                              | brick_empty, lod colour, count
//
//  voxel access: states FETCH, APPLY, FINISH, then into the output register
//  summary: channels in turn, one quotient bit a cycle in the shared divider
//  reset clears state, occupancy, sums and count; colour memory is not cleared
//  in_stall is high while an item is in work; a result waits in the output
//  register and the next item may enter meanwhile
`include "voxel_brick_store_defines.svh"

module voxel_brick_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  vbs_pkg::kind_t                      kind,
    input  logic signed [vbs_pkg::POS_W-1:0]    pos_x,
    input  logic signed [vbs_pkg::POS_W-1:0]    pos_y,
    input  logic signed [vbs_pkg::POS_W-1:0]    pos_z,
    input  logic [vbs_pkg::CH_W-1:0]            red_in,
    input  logic [vbs_pkg::CH_W-1:0]            green_in,
    input  logic [vbs_pkg::CH_W-1:0]            blue_in,
    input  logic [vbs_pkg::CH_W-1:0]            alpha_in,
    input  logic                                replace,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                bad_position,
    output logic                                solid,
    output logic [vbs_pkg::CH_W-1:0]            red_out,
    output logic [vbs_pkg::CH_W-1:0]            green_out,
    output logic [vbs_pkg::CH_W-1:0]            blue_out,
    output logic [vbs_pkg::CH_W-1:0]            alpha_out,
    output logic                                brick_empty,
    output logic [vbs_pkg::CH_W-1:0]            lod_red,
    output logic [vbs_pkg::CH_W-1:0]            lod_green,
    output logic [vbs_pkg::CH_W-1:0]            lod_blue,
    output logic [vbs_pkg::CNT_W-1:0]           solid_count
);

    import vbs_pkg::*;

    state_t                  state_reg, state_next;
    kind_t                   kind_reg;
    logic                    bad_reg;
    logic [COORD_W-1:0]      x_reg, y_reg, z_reg;
    logic [COLOUR_W-1:0]     colour_reg;
    logic                    replace_reg;
    logic [LAYER_BITS-1:0]   occ_reg [EDGE];
    logic [SUM_W-1:0]        sum_red_reg, sum_green_reg, sum_blue_reg;
    logic [CNT_W-1:0]        count_reg;

    chan_t                   chan_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [SUM_W-1:0]        dq_reg;
    logic [CH_W-1:0]         avg_red_reg, avg_green_reg, avg_blue_reg;

    logic                    out_valid_reg;
    logic                    bad_position_reg, solid_reg, brick_empty_reg;
    logic [CH_W-1:0]         red_out_reg, green_out_reg, blue_out_reg, alpha_out_reg;
    logic [CH_W-1:0]         lod_red_reg, lod_green_reg, lod_blue_reg;
    logic [CNT_W-1:0]        solid_count_reg;

    logic                    in_take;
    logic                    out_load;
    logic                    pos_ok;
    logic [IDX_W-1:0]        voxel_idx;
    logic [LAYER_IDX_W-1:0]  bit_idx;
    logic                    was_solid;
    logic                    do_clear, do_set, take_old;
    logic [COLOUR_W-1:0]     old_colour;
    logic [CH_W-1:0]         sub_r, sub_g, sub_b, add_r, add_g, add_b;
    logic [CNT_W:0]          trial;
    logic                    trial_ge;
    logic [CNT_W-1:0]        rem_step;
    logic [SUM_W-1:0]        dq_step;
    logic                    read_hit;

    vbs_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (VOXELS)
    ) u_colour_ram (
        .clk     (clk),
        .wr_en   (state_reg == ST_APPLY && do_set),
        .wr_addr (voxel_idx),
        .wr_data (colour_reg),
        .rd_en   (state_reg == ST_FETCH),
        .rd_addr (voxel_idx),
        .rd_data (old_colour)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    assign pos_ok = ($unsigned(pos_x) < POS_W'(EDGE)) && ($unsigned(pos_y) < POS_W'(EDGE))
                    && ($unsigned(pos_z) < POS_W'(EDGE));

    assign voxel_idx = IDX_W'(y_reg) * IDX_W'(LAYER_BITS) + IDX_W'(z_reg) * IDX_W'(EDGE)
                       + IDX_W'(x_reg);
    assign bit_idx   = LAYER_IDX_W'(z_reg) * LAYER_IDX_W'(EDGE) + LAYER_IDX_W'(x_reg);
    assign was_solid = occ_reg[y_reg][bit_idx];

    assign do_clear = !bad_reg && (kind_reg == KIND_CLEAR) && was_solid;
    assign do_set   = !bad_reg && (kind_reg == KIND_SET) && (!was_solid || replace_reg);
    assign take_old = do_clear || (do_set && was_solid);
    assign read_hit = !bad_reg && (kind_reg == KIND_READ) && was_solid;

    always_comb
    begin
        sub_r = take_old ? old_colour[CH_W-1:0]          : '0;
        sub_g = take_old ? old_colour[2*CH_W-1:CH_W]     : '0;
        sub_b = take_old ? old_colour[3*CH_W-1:2*CH_W]   : '0;
        add_r = do_set   ? colour_reg[CH_W-1:0]          : '0;
        add_g = do_set   ? colour_reg[2*CH_W-1:CH_W]     : '0;
        add_b = do_set   ? colour_reg[3*CH_W-1:2*CH_W]   : '0;
    end

    // restoring divide step, one quotient bit
    always_comb
    begin
        trial    = {rem_reg, dq_reg[SUM_W-1]};
        trial_ge = trial >= {1'b0, count_reg};
        rem_step = trial_ge ? CNT_W'(trial - {1'b0, count_reg}) : CNT_W'(trial);
        dq_step  = {dq_reg[SUM_W-2:0], trial_ge};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (kind_reg == KIND_SUMMARY && count_reg != '0)
                begin
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (step_reg == STEP_W'(SUM_W - 1) && chan_reg == CHAN_BLUE)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            chan_reg      <= CHAN_RED;
            step_reg      <= '0;
            for (int i = 0; i < EDGE; i++)
            begin
                occ_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_APPLY)
            begin
                sum_red_reg   <= sum_red_reg - SUM_W'(sub_r) + SUM_W'(add_r);
                sum_green_reg <= sum_green_reg - SUM_W'(sub_g) + SUM_W'(add_g);
                sum_blue_reg  <= sum_blue_reg - SUM_W'(sub_b) + SUM_W'(add_b);
                if (do_clear)
                begin
                    occ_reg[y_reg][bit_idx] <= 1'b0;
                    count_reg               <= count_reg - CNT_W'(1);
                end
                else if (do_set)
                begin
                    occ_reg[y_reg][bit_idx] <= 1'b1;
                    if (!was_solid)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                chan_reg <= CHAN_RED;
                step_reg <= '0;
            end
            else if (state_reg == ST_DIVIDE)
            begin
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    step_reg <= '0;
                    priority case (chan_reg)
                        CHAN_RED:   chan_reg <= CHAN_GREEN;
                        CHAN_GREEN: chan_reg <= CHAN_BLUE;
                        default:    chan_reg <= CHAN_RED;
                    endcase
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, divider and output registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg    <= kind;
            bad_reg     <= (kind != KIND_SUMMARY) && !pos_ok;
            x_reg       <= pos_x[COORD_W-1:0];
            y_reg       <= pos_y[COORD_W-1:0];
            z_reg       <= pos_z[COORD_W-1:0];
            colour_reg  <= {alpha_in, blue_in, green_in, red_in};
            replace_reg <= replace;
        end

        if (state_reg == ST_APPLY)
        begin
            avg_red_reg   <= '0;
            avg_green_reg <= '0;
            avg_blue_reg  <= '0;
            dq_reg        <= sum_red_reg;
            rem_reg       <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                rem_reg <= '0;
                priority case (chan_reg)
                    CHAN_RED:
                    begin
                        avg_red_reg <= dq_step[CH_W-1:0];
                        dq_reg      <= sum_green_reg;
                    end
                    CHAN_GREEN:
                    begin
                        avg_green_reg <= dq_step[CH_W-1:0];
                        dq_reg        <= sum_blue_reg;
                    end
                    default:
                    begin
                        avg_blue_reg <= dq_step[CH_W-1:0];
                        dq_reg       <= dq_step;
                    end
                endcase
            end
            else
            begin
                rem_reg <= rem_step;
                dq_reg  <= dq_step;
            end
        end

        if (out_load)
        begin
            bad_position_reg <= bad_reg;
            solid_reg        <= read_hit;
            red_out_reg      <= read_hit ? old_colour[CH_W-1:0]          : '0;
            green_out_reg    <= read_hit ? old_colour[2*CH_W-1:CH_W]     : '0;
            blue_out_reg     <= read_hit ? old_colour[3*CH_W-1:2*CH_W]   : '0;
            alpha_out_reg    <= read_hit ? old_colour[4*CH_W-1:3*CH_W]   : '0;
            brick_empty_reg  <= (kind_reg == KIND_SUMMARY) && (count_reg == '0);
            lod_red_reg      <= (kind_reg == KIND_SUMMARY) ? avg_red_reg   : '0;
            lod_green_reg    <= (kind_reg == KIND_SUMMARY) ? avg_green_reg : '0;
            lod_blue_reg     <= (kind_reg == KIND_SUMMARY) ? avg_blue_reg  : '0;
            solid_count_reg  <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bad_position = bad_position_reg;
    assign solid        = solid_reg;
    assign red_out      = red_out_reg;
    assign green_out    = green_out_reg;
    assign blue_out     = blue_out_reg;
    assign alpha_out    = alpha_out_reg;
    assign brick_empty  = brick_empty_reg;
    assign lod_red      = lod_red_reg;
    assign lod_green    = lod_green_reg;
    assign lod_blue     = lod_blue_reg;
    assign solid_count  = solid_count_reg;

    `VBS_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_W'(VOXELS))
    `VBS_ASSERT_NOW(a_empty_lod_zero, out_valid_reg && brick_empty_reg, lod_red_reg == '0 && lod_green_reg == '0 && lod_blue_reg == '0)
    `VBS_ASSERT_NOW(a_bad_not_solid, out_valid_reg && bad_position_reg, !solid_reg)
    `VBS_ASSERT_NEXT(a_div_ends, state_reg == ST_DIVIDE && step_reg == STEP_W'(SUM_W - 1) && chan_reg == CHAN_BLUE, state_reg == ST_FINISH)

endmodule

FILE: sim/tb_voxel_brick_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_brick_store
// self-checking bench for the voxel brick store: directed voxel and summary
// accesses, out-of-brick coordinates, a full fill, random traffic with idle
// bursts on both channels, a steady stream, all checked against a local model
// ----------------------------------------------------------------------------
module tb_voxel_brick_store;

    import vbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_ITEMS   = 40;
    localparam int STEADY_ITEMS   = 20;
    localparam int SHOWN_ERRORS   = 10;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    alpha;
        logic               replace;
    } voxel_access_t;

    typedef struct packed {
        logic               bad_position;
        logic               solid;
        logic [CH_W-1:0]    red_out;
        logic [CH_W-1:0]    green_out;
        logic [CH_W-1:0]    blue_out;
        logic [CH_W-1:0]    alpha_out;
        logic               brick_empty;
        logic [CH_W-1:0]    lod_red;
        logic [CH_W-1:0]    lod_green;
        logic [CH_W-1:0]    lod_blue;
        logic [CNT_W-1:0]   solid_count;
    } brick_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    kind_t                      kind = KIND_CLEAR;
    logic signed [POS_W-1:0]    pos_x = '0;
    logic signed [POS_W-1:0]    pos_y = '0;
    logic signed [POS_W-1:0]    pos_z = '0;
    logic [CH_W-1:0]            red_in = '0;
    logic [CH_W-1:0]            green_in = '0;
    logic [CH_W-1:0]            blue_in = '0;
    logic [CH_W-1:0]            alpha_in = '0;
    logic                       replace = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       bad_position;
    logic                       solid;
    logic [CH_W-1:0]            red_out;
    logic [CH_W-1:0]            green_out;
    logic [CH_W-1:0]            blue_out;
    logic [CH_W-1:0]            alpha_out;
    logic                       brick_empty;
    logic [CH_W-1:0]            lod_red;
    logic [CH_W-1:0]            lod_green;
    logic [CH_W-1:0]            lod_blue;
    logic [CNT_W-1:0]           solid_count;

    // brick model
    logic [LAYER_BITS-1:0]      layer_mask [EDGE];
    logic [COLOUR_W-1:0]        colour_mem [VOXELS];
    logic [SUM_W-1:0]           red_total;
    logic [SUM_W-1:0]           green_total;
    logic [SUM_W-1:0]           blue_total;
    logic [CNT_W-1:0]           solid_total;

    brick_result_t              pending_results [$];
    brick_result_t              seen_result;
    brick_result_t              want_result;
    logic                       steady_phase = 1'b0;
    int                         stall_left = 0;
    int                         idle_cycles = 0;
    int                         fail_count = 0;
    int                         items_sent = 0;
    int                         summaries_sent = 0;
    int                         outside_sent = 0;
    int                         results_checked = 0;
    int                         peak_count = 0;

    voxel_brick_store DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .alpha_in     (alpha_in),
        .replace      (replace),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bad_position (bad_position),
        .solid        (solid),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .alpha_out    (alpha_out),
        .brick_empty  (brick_empty),
        .lod_red      (lod_red),
        .lod_green    (lod_green),
        .lod_blue     (lod_blue),
        .solid_count  (solid_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void adjust_totals(input logic [COLOUR_W-1:0] c, input logic grow);
        if (grow)
        begin
            red_total   = red_total + c[7:0];
            green_total = green_total + c[15:8];
            blue_total  = blue_total + c[23:16];
        end
        else
        begin
            red_total   = red_total - c[7:0];
            green_total = green_total - c[15:8];
            blue_total  = blue_total - c[23:16];
        end
    endfunction

    function automatic brick_result_t predict_access(input voxel_access_t a);
        brick_result_t          r;
        logic [LAYER_BITS-1:0]  any_solid;
        logic [LAYER_IDX_W-1:0] bit_at;
        logic [COORD_W-1:0]     layer;
        logic [IDX_W-1:0]       vox;
        logic                   in_brick;
        logic                   was_solid;
        r = '0;
        in_brick = a.pos_x < EDGE && a.pos_y < EDGE && a.pos_z < EDGE;
        if (a.kind == KIND_SUMMARY)
        begin
            any_solid = '0;
            for (int i = 0; i < EDGE; i++)
                any_solid = any_solid | layer_mask[i];
            r.brick_empty = (any_solid == '0);
            if (solid_total != '0)
            begin
                r.lod_red   = CH_W'(red_total / solid_total);
                r.lod_green = CH_W'(green_total / solid_total);
                r.lod_blue  = CH_W'(blue_total / solid_total);
            end
        end
        else if (!in_brick)
            r.bad_position = 1'b1;
        else
        begin
            // bit z*EDGE + x within layer y
            bit_at = {a.pos_z[COORD_W-1:0], a.pos_x[COORD_W-1:0]};
            layer = a.pos_y[COORD_W-1:0];
            vox = {layer, bit_at};
            was_solid = layer_mask[layer][bit_at];
            case (a.kind)
                KIND_CLEAR:
                begin
                    if (was_solid)
                    begin
                        layer_mask[layer][bit_at] = 1'b0;
                        adjust_totals(colour_mem[vox], 1'b0);
                        solid_total = solid_total - 1'b1;
                    end
                end
                KIND_SET:
                begin
                    if (!was_solid || a.replace)
                    begin
                        if (was_solid)
                            adjust_totals(colour_mem[vox], 1'b0);
                        else
                            solid_total = solid_total + 1'b1;
                        layer_mask[layer][bit_at] = 1'b1;
                        colour_mem[vox] = {a.alpha, a.blue, a.green, a.red};
                        adjust_totals(colour_mem[vox], 1'b1);
                    end
                end
                default:
                begin
                    if (was_solid)
                    begin
                        r.solid = 1'b1;
                        {r.alpha_out, r.blue_out, r.green_out, r.red_out} = colour_mem[vox];
                    end
                end
            endcase
        end
        r.solid_count = solid_total;
        return r;
    endfunction

    function automatic string show_result(input brick_result_t r);
        return $sformatf("bad=%0b solid=%0b rgba=%0d/%0d/%0d/%0d empty=%0b lod=%0d/%0d/%0d count=%0d",
                         r.bad_position, r.solid, r.red_out, r.green_out, r.blue_out,
                         r.alpha_out, r.brick_empty, r.lod_red, r.lod_green, r.lod_blue,
                         r.solid_count);
    endfunction

    function automatic voxel_access_t voxel_op(input kind_t k, input int x, input int y,
                                               input int z, input logic [COLOUR_W-1:0] c,
                                               input logic rep);
        voxel_access_t a;
        a.kind    = k;
        a.pos_x   = POS_W'(x);
        a.pos_y   = POS_W'(y);
        a.pos_z   = POS_W'(z);
        {a.alpha, a.blue, a.green, a.red} = c;
        a.replace = rep;
        return a;
    endfunction

    function automatic logic [POS_W-1:0] random_coord();
        if ($urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(0, EDGE - 1));
        return POS_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CH_W-1:0] random_level();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return CH_W'($urandom_range(0, 255));
    endfunction

    function automatic voxel_access_t random_access();
        voxel_access_t a;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            a.kind = KIND_SET;
        else if (pick < 65)
            a.kind = KIND_CLEAR;
        else if (pick < 90)
            a.kind = KIND_READ;
        else
            a.kind = KIND_SUMMARY;
        a.pos_x   = random_coord();
        a.pos_y   = random_coord();
        a.pos_z   = random_coord();
        a.red     = random_level();
        a.green   = random_level();
        a.blue    = random_level();
        a.alpha   = random_level();
        a.replace = 1'($urandom_range(0, 1));
        return a;
    endfunction

    // called at a rising edge; returns at the edge of the transfer or after a gap
    task automatic push_access(input voxel_access_t a);
        brick_result_t r;
        kind     <= a.kind;
        pos_x    <= a.pos_x;
        pos_y    <= a.pos_y;
        pos_z    <= a.pos_z;
        red_in   <= a.red;
        green_in <= a.green;
        blue_in  <= a.blue;
        alpha_in <= a.alpha;
        replace  <= a.replace;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        r = predict_access(a);
        pending_results = {pending_results, r};
        items_sent++;
        if (a.kind == KIND_SUMMARY)
            summaries_sent++;
        if (r.bad_position)
            outside_sent++;
        if (!steady_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic test_voxel_basics;
        push_access(voxel_op(KIND_SUMMARY, 0, 0, 0, 32'h0, 1'b0));
        push_access(voxel_op(KIND_READ, 0, 0, 0, 32'h0, 1'b0));
        push_access(voxel_op(KIND_CLEAR, 7, 7, 7, 32'h0, 1'b0));
        push_access(voxel_op(KIND_SET, 0, 0, 0, 32'h0, 1'b0));
        push_access(voxel_op(KIND_SET, 7, 7, 7, 32'hFFFF_FFFF, 1'b1));
        push_access(voxel_op(KIND_SUMMARY, 0, 0, 0, 32'h0, 1'b0));
        push_access(voxel_op(KIND_SET, 7, 7, 7, 32'h0403_0201, 1'b0));
        push_access(voxel_op(KIND_READ, 7, 7, 7, 32'h0, 1'b0));
        push_access(voxel_op(KIND_SET, 7, 7, 7, 32'h1020_4080, 1'b1));
        push_access(voxel_op(KIND_READ, 7, 7, 7, 32'h0, 1'b0));
        push_access(voxel_op(KIND_READ, 6, 7, 7, 32'h0, 1'b0));
        push_access(voxel_op(KIND_SUMMARY, 0, 0, 0, 32'h0, 1'b0));
        push_access(voxel_op(KIND_CLEAR, 0, 0, 0, 32'h0, 1'b0));
        push_access(voxel_op(KIND_READ, 0, 0, 0, 32'h0, 1'b0));
    endtask

    task automatic test_outside_brick;
        push_access(voxel_op(KIND_SET, -1, 0, 0, 32'hFFFF_FFFF, 1'b1));
        push_access(voxel_op(KIND_SET, 0, 8, 0, 32'hFFFF_FFFF, 1'b1));
        push_access(voxel_op(KIND_CLEAR, 7, 7, 127, 32'h0, 1'b0));
        push_access(voxel_op(KIND_READ, -128, 7, 7, 32'h0, 1'b0));
        push_access(voxel_op(KIND_READ, 7, -1, 7, 32'h0, 1'b0));
        push_access(voxel_op(KIND_READ, 7, 7, 8, 32'h0, 1'b0));
        push_access(voxel_op(KIND_SUMMARY, -128, 127, -1, 32'h0, 1'b0));
        push_access(voxel_op(KIND_CLEAR, 7, 7, 7, 32'h0, 1'b0));
        push_access(voxel_op(KIND_SUMMARY, 0, 0, 0, 32'h0, 1'b0));
    endtask

    // every voxel solid with full red, green and blue, summaries along the way
    task automatic test_fill_brick;
        logic [CH_W-1:0] shade;
        for (int v = 0; v < VOXELS; v++)
        begin
            shade = random_level();
            push_access(voxel_op(KIND_SET, v % EDGE, v / (EDGE * EDGE), (v / EDGE) % EDGE,
                                 {shade, 24'hFF_FFFF}, 1'($urandom_range(0, 1))));
            if (v % (EDGE * EDGE) == EDGE * EDGE - 1)
                push_access(voxel_op(KIND_SUMMARY, 0, 0, 0, 32'h0, 1'b0));
        end
    endtask

    task automatic test_random_traffic;
        for (int n = 0; n < RANDOM_ITEMS; n++)
            push_access(random_access());
    endtask

    task automatic test_steady_stream;
        steady_phase <= 1'b1;
        for (int n = 0; n < STEADY_ITEMS; n++)
            push_access(random_access());
    endtask

    // output side idle bursts
    always @(posedge clk)
    begin
        if (!rst_n || steady_phase)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_result.bad_position = bad_position;
            seen_result.solid        = solid;
            seen_result.red_out      = red_out;
            seen_result.green_out    = green_out;
            seen_result.blue_out     = blue_out;
            seen_result.alpha_out    = alpha_out;
            seen_result.brick_empty  = brick_empty;
            seen_result.lod_red      = lod_red;
            seen_result.lod_green    = lod_green;
            seen_result.lod_blue     = lod_blue;
            seen_result.solid_count  = solid_count;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS)
                    $display("unexpected result: %s", show_result(seen_result));
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (want_result.solid_count > peak_count)
                    peak_count = int'(want_result.solid_count);
                if (seen_result !== want_result)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", show_result(want_result));
                        $display("  actual   %s", show_result(seen_result));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < EDGE; i++)
            layer_mask[i] = '0;
        red_total   = '0;
        green_total = '0;
        blue_total  = '0;
        solid_total = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_voxel_basics();
        test_outside_brick();
        test_fill_brick();
        test_random_traffic();
        test_steady_stream();

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d accesses sent: %0d summaries, %0d outside the brick, full fill included",
                 items_sent, summaries_sent, outside_sent);
        $display("%0d results compared, peak solid count %0d, %0d mismatches",
                 results_checked, peak_count, fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
